FILE: hdl/alt_pkg.sv
// Shared constants, codes and controller/datapath command types for the array list table.
package alt_pkg;

	localparam int CAPACITY     = 32;
	localparam int RESULT_LIMIT = 32;
	localparam int IDX_W        = $clog2(CAPACITY);
	localparam int CNT_W        = $clog2(CAPACITY + 1);

	localparam int OP_W   = 3;
	localparam int POS_W  = 6;
	localparam int WORD_W = 32;
	localparam int ST_W   = 3;
	localparam int FIDX_W = 5;
	localparam int LEN_W  = 6;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 3'd0,
		OP_APPEND  = 3'd1,
		OP_INSERT  = 3'd2,
		OP_DELETE  = 3'd3,
		OP_SEARCH  = 3'd4,
		OP_DISPLAY = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PTR_HOLD     = 3'd0,
		PTR_LD_ZERO  = 3'd1,
		PTR_LD_COUNT = 3'd2,
		PTR_LD_POS   = 3'd3,
		PTR_INC      = 3'd4,
		PTR_DEC      = 3'd5
	} ptr_op_t;

	typedef enum logic [1:0] {
		RD_PTR    = 2'd0,
		RD_PTR_M1 = 2'd1,
		RD_PTR_P1 = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_AT_COUNT = 2'd0,
		WR_AT_POS   = 2'd1,
		WR_AT_PTR   = 2'd2
	} wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_CLR  = 2'd1,
		CNT_INC  = 2'd2,
		CNT_DEC  = 2'd3
	} cnt_op_t;

	typedef enum logic [1:0] {
		IDX_ZERO  = 2'd0,
		IDX_COUNT = 2'd1,
		IDX_POS   = 2'd2,
		IDX_PTR   = 2'd3
	} idx_sel_t;

	typedef enum logic [1:0] {
		DATA_ZERO  = 2'd0,
		DATA_VAL   = 2'd1,
		DATA_RDATA = 2'd2
	} data_sel_t;

	typedef struct packed {
		logic      capture;
		ptr_op_t   ptr_op;
		logic      mem_re;
		rd_sel_t   rd_sel;
		logic      mem_we;
		wr_sel_t   wr_sel;
		cnt_op_t   cnt_op;
		logic      out_ld;
		status_t   out_status;
		idx_sel_t  idx_sel;
		data_sel_t data_sel;
		logic      out_last;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic pos_gt_count;
		logic pos_ge_count;
		logic ptr_eq_pos;
		logic ptr_eq_count;
		logic del_done;
		logic hit;
		logic disp_last;
		logic out_free;
	} dp_stat_t;

	localparam dp_cmd_t CMD_NOP = '{
		capture:    1'b0,
		ptr_op:     PTR_HOLD,
		mem_re:     1'b0,
		rd_sel:     RD_PTR,
		mem_we:     1'b0,
		wr_sel:     WR_AT_COUNT,
		cnt_op:     CNT_HOLD,
		out_ld:     1'b0,
		out_status: ST_OK,
		idx_sel:    IDX_ZERO,
		data_sel:   DATA_ZERO,
		out_last:   1'b0
	};

endpackage

FILE: hdl/alt_if.sv
// Valid/ready channel interfaces for commands and results of the array list table.
interface alt_in_if;
	logic                              valid;
	logic                              ready;
	logic [alt_pkg::OP_W-1:0]          operation;
	logic [alt_pkg::POS_W-1:0]         position;
	logic signed [alt_pkg::WORD_W-1:0] value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);
endinterface

interface alt_out_if;
	logic                              valid;
	logic                              ready;
	logic [alt_pkg::ST_W-1:0]          status;
	logic [alt_pkg::FIDX_W-1:0]        found_index;
	logic signed [alt_pkg::WORD_W-1:0] data_word;
	logic [alt_pkg::LEN_W-1:0]         length;
	logic                              last;

	modport source (output valid, output status, output found_index, output data_word,
		output length, output last, input ready);
	modport sink (input valid, input status, input found_index, input data_word,
		input length, input last, output ready);
endinterface

FILE: hdl/array_list_table.sv
// Top level of the array list table: joins the command sequencer and the datapath.
//
//   channel  dir  beat fields
//   req      in   operation[2:0] position[5:0] value[31:0]
//   rsp      out  status[2:0] found_index[4:0] data_word[31:0] length[5:0] last
//
// Clear and append finish in the decode step. Insert and delete shift the entries
// behind position, search walks the list to a hit or its end, display walks up to
// the result limit; the registered-read entry memory moves one entry per read/use pair.
// Reset clears the count and the sequencer; the entry memory keeps no reset.
// req is taken while a result waits in the output register; a stalled rsp holds
// the sequencer at the step that produces the next result.
module array_list_table (
	input logic clk,
	input logic arst_n,
	alt_in_if.sink    req,
	alt_out_if.source rsp
);
	import alt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	alt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	alt_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.operation   (req.operation),
		.position    (req.position),
		.value       (req.value),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.status      (rsp.status),
		.found_index (rsp.found_index),
		.data_word   (rsp.data_word),
		.length      (rsp.length),
		.last        (rsp.last)
	);

endmodule

FILE: hdl/alt_ctrl.sv
// Command sequencer: walks each list command through decode, read and use steps.
module alt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  alt_pkg::dp_stat_t stat,
	output alt_pkg::dp_cmd_t  cmd
);
	import alt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_READ   = 4'b0100,
		S_USE    = 4'b1000
	} state_t;

	state_t state_q, state_d;

	function automatic dp_cmd_t put_result(dp_cmd_t c, status_t s, idx_sel_t i,
		data_sel_t d);
		dp_cmd_t r;
		r            = c;
		r.out_ld     = 1'b1;
		r.out_status = s;
		r.idx_sel    = i;
		r.data_sel   = d;
		r.out_last   = 1'b1;
		return r;
	endfunction

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = CMD_NOP;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					OP_CLEAR: begin
						if (stat.out_free) begin
							cmd.cnt_op = CNT_CLR;
							cmd        = put_result(cmd, ST_OK, IDX_ZERO, DATA_ZERO);
							state_d    = S_IDLE;
						end
					end
					OP_APPEND: begin
						if (stat.out_free) begin
							if (stat.full) begin
								cmd = put_result(cmd, ST_FULL, IDX_ZERO, DATA_ZERO);
							end else begin
								cmd.mem_we = 1'b1;
								cmd.wr_sel = WR_AT_COUNT;
								cmd.cnt_op = CNT_INC;
								cmd        = put_result(cmd, ST_OK, IDX_COUNT, DATA_ZERO);
							end
							state_d = S_IDLE;
						end
					end
					OP_INSERT: begin
						if (stat.full) begin
							if (stat.out_free) begin
								cmd     = put_result(cmd, ST_FULL, IDX_ZERO, DATA_ZERO);
								state_d = S_IDLE;
							end
						end else if (stat.pos_gt_count) begin
							if (stat.out_free) begin
								cmd     = put_result(cmd, ST_BADPOS, IDX_ZERO, DATA_ZERO);
								state_d = S_IDLE;
							end
						end else begin
							cmd.ptr_op = PTR_LD_COUNT;
							state_d    = S_READ;
						end
					end
					OP_DELETE: begin
						if (stat.empty) begin
							if (stat.out_free) begin
								cmd     = put_result(cmd, ST_EMPTY, IDX_ZERO, DATA_ZERO);
								state_d = S_IDLE;
							end
						end else if (stat.pos_ge_count) begin
							if (stat.out_free) begin
								cmd     = put_result(cmd, ST_BADPOS, IDX_ZERO, DATA_ZERO);
								state_d = S_IDLE;
							end
						end else begin
							cmd.ptr_op = PTR_LD_POS;
							state_d    = S_READ;
						end
					end
					OP_SEARCH, OP_DISPLAY: begin
						if (stat.empty) begin
							if (stat.out_free) begin
								cmd     = put_result(cmd, ST_EMPTY, IDX_ZERO, DATA_ZERO);
								state_d = S_IDLE;
							end
						end else begin
							cmd.ptr_op = PTR_LD_ZERO;
							state_d    = S_READ;
						end
					end
					default: begin
						// unused codes: drop the beat without a result
						state_d = S_IDLE;
					end
				endcase
			end
			S_READ: begin
				case (stat.op)
					OP_INSERT: begin
						if (stat.ptr_eq_pos) begin
							if (stat.out_free) begin
								cmd.mem_we = 1'b1;
								cmd.wr_sel = WR_AT_POS;
								cmd.cnt_op = CNT_INC;
								cmd        = put_result(cmd, ST_OK, IDX_POS, DATA_ZERO);
								state_d    = S_IDLE;
							end
						end else begin
							cmd.mem_re = 1'b1;
							cmd.rd_sel = RD_PTR_M1;
							state_d    = S_USE;
						end
					end
					OP_DELETE: begin
						if (stat.del_done) begin
							if (stat.out_free) begin
								cmd.cnt_op = CNT_DEC;
								cmd        = put_result(cmd, ST_OK, IDX_POS, DATA_ZERO);
								state_d    = S_IDLE;
							end
						end else begin
							cmd.mem_re = 1'b1;
							cmd.rd_sel = RD_PTR_P1;
							state_d    = S_USE;
						end
					end
					OP_SEARCH: begin
						if (stat.ptr_eq_count) begin
							if (stat.out_free) begin
								cmd     = put_result(cmd, ST_NOTFOUND, IDX_ZERO, DATA_ZERO);
								state_d = S_IDLE;
							end
						end else begin
							cmd.mem_re = 1'b1;
							cmd.rd_sel = RD_PTR;
							state_d    = S_USE;
						end
					end
					OP_DISPLAY: begin
						cmd.mem_re = 1'b1;
						cmd.rd_sel = RD_PTR;
						state_d    = S_USE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_USE: begin
				case (stat.op)
					OP_INSERT: begin
						cmd.mem_we = 1'b1;
						cmd.wr_sel = WR_AT_PTR;
						cmd.ptr_op = PTR_DEC;
						state_d    = S_READ;
					end
					OP_DELETE: begin
						cmd.mem_we = 1'b1;
						cmd.wr_sel = WR_AT_PTR;
						cmd.ptr_op = PTR_INC;
						state_d    = S_READ;
					end
					OP_SEARCH: begin
						if (stat.hit) begin
							if (stat.out_free) begin
								cmd     = put_result(cmd, ST_OK, IDX_PTR, DATA_VAL);
								state_d = S_IDLE;
							end
						end else begin
							cmd.ptr_op = PTR_INC;
							state_d    = S_READ;
						end
					end
					OP_DISPLAY: begin
						// hold the read word until the result slot frees up
						if (stat.out_free) begin
							cmd          = put_result(cmd, ST_OK, IDX_PTR, DATA_RDATA);
							cmd.out_last = stat.disp_last;
							if (stat.disp_last) begin
								state_d = S_IDLE;
							end else begin
								cmd.ptr_op = PTR_INC;
								state_d    = S_READ;
							end
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/alt_dpath.sv
// Datapath: entry memory, count and walk pointer, comparators and the result register.
module alt_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  alt_pkg::dp_cmd_t                  cmd,
	output alt_pkg::dp_stat_t                 stat,
	input  logic [alt_pkg::OP_W-1:0]          operation,
	input  logic [alt_pkg::POS_W-1:0]         position,
	input  logic signed [alt_pkg::WORD_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [alt_pkg::ST_W-1:0]          status,
	output logic [alt_pkg::FIDX_W-1:0]        found_index,
	output logic signed [alt_pkg::WORD_W-1:0] data_word,
	output logic [alt_pkg::LEN_W-1:0]         length,
	output logic                              last
);
	import alt_pkg::*;

	logic signed [WORD_W-1:0] mem [CAPACITY];

	op_t                      op_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [WORD_W-1:0] val_q;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [CNT_W-1:0]         ptr_q;
	logic signed [WORD_W-1:0] rdata_q;

	logic                     out_valid_q;
	logic [ST_W-1:0]          status_q;
	logic [FIDX_W-1:0]        fidx_q;
	logic signed [WORD_W-1:0] data_q;
	logic [LEN_W-1:0]         len_q;
	logic                     last_q;

	logic [31:0]              cnt32, pos32, ptr32, lim32, ra32, wa32, idx32, len32;
	logic [IDX_W-1:0]         rd_addr, wr_addr;
	logic signed [WORD_W-1:0] wr_data, res_data;
	logic                     out_free;

	assign cnt32 = 32'(count_q);
	assign pos32 = 32'(pos_q);
	assign ptr32 = 32'(ptr_q);
	assign lim32 = (cnt32 < RESULT_LIMIT) ? cnt32 : 32'(RESULT_LIMIT);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		stat.op           = op_q;
		stat.full         = (cnt32 >= CAPACITY);
		stat.empty        = (count_q == '0);
		stat.pos_gt_count = (pos32 > cnt32);
		stat.pos_ge_count = (pos32 >= cnt32);
		stat.ptr_eq_pos   = (ptr32 == pos32);
		stat.ptr_eq_count = (ptr32 == cnt32);
		stat.del_done     = (ptr32 + 32'd1 >= cnt32);
		stat.hit          = (rdata_q == val_q);
		stat.disp_last    = (ptr32 + 32'd1 == lim32);
		stat.out_free     = out_free;
	end

	// memory addressing
	always_comb begin
		case (cmd.rd_sel)
			RD_PTR_M1: ra32 = ptr32 - 32'd1;
			RD_PTR_P1: ra32 = ptr32 + 32'd1;
			default:   ra32 = ptr32;
		endcase
		case (cmd.wr_sel)
			WR_AT_POS: begin
				wa32    = pos32;
				wr_data = val_q;
			end
			WR_AT_PTR: begin
				wa32    = ptr32;
				wr_data = rdata_q;
			end
			default: begin
				wa32    = cnt32;
				wr_data = val_q;
			end
		endcase
	end

	assign rd_addr = ra32[IDX_W-1:0];
	assign wr_addr = wa32[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.mem_re) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_comb begin
		case (cmd.cnt_op)
			CNT_CLR: count_d = '0;
			CNT_INC: count_d = count_q + CNT_W'(1);
			CNT_DEC: count_d = count_q - CNT_W'(1);
			default: count_d = count_q;
		endcase
		case (cmd.idx_sel)
			IDX_COUNT: idx32 = cnt32;
			IDX_POS:   idx32 = pos32;
			IDX_PTR:   idx32 = ptr32;
			default:   idx32 = '0;
		endcase
		case (cmd.data_sel)
			DATA_VAL:   res_data = val_q;
			DATA_RDATA: res_data = rdata_q;
			default:    res_data = '0;
		endcase
	end

	assign len32 = 32'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(operation);
			pos_q <= position;
			val_q <= value;
		end
		case (cmd.ptr_op)
			PTR_LD_ZERO:  ptr_q <= '0;
			PTR_LD_COUNT: ptr_q <= count_q;
			PTR_LD_POS:   ptr_q <= pos32[CNT_W-1:0];
			PTR_INC:      ptr_q <= ptr_q + CNT_W'(1);
			PTR_DEC:      ptr_q <= ptr_q - CNT_W'(1);
			default:      ptr_q <= ptr_q;
		endcase
		if (cmd.out_ld) begin
			status_q <= cmd.out_status;
			fidx_q   <= idx32[FIDX_W-1:0];
			data_q   <= res_data;
			len_q    <= len32[LEN_W-1:0];
			last_q   <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = fidx_q;
	assign data_word   = data_q;
	assign length      = len_q;
	assign last        = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt32 <= CAPACITY)
		else $error("entry count above capacity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> out_free)
		else $error("result loaded over an untaken beat");

	a_count_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.out_ld |=> $stable(count_q))
		else $error("count changed without a result");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we |-> (wa32 < CAPACITY))
		else $error("memory write beyond capacity");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for array_list_table: a table of commands, then random list traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import alt_pkg::*;

	localparam int RANDOM_ITEMS    = 140;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int QUIET_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 80;
	localparam int TABLE_ROWS      = 22;

	// Codes outside the operation set: the block must ignore them
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	typedef struct packed {
		status_t             status;
		logic [FIDX_W-1:0]   idx;
		logic [WORD_W-1:0]   word;
		logic [LEN_W-1:0]    len;
		logic                is_last;
	} rsp_beat_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] val;
		logic              typed;
		rsp_beat_t         beat;
	} cmd_row_t;

	localparam cmd_row_t COMMAND_TABLE [TABLE_ROWS] = '{
		'{OP_DISPLAY, 6'd0,  32'd0,          1'b1, '{ST_EMPTY,    5'd0, 32'd0,          6'd0, 1'b1}},
		'{OP_DELETE,  6'd0,  32'd0,          1'b1, '{ST_EMPTY,    5'd0, 32'd0,          6'd0, 1'b1}},
		'{OP_SEARCH,  6'd0,  32'd0,          1'b1, '{ST_EMPTY,    5'd0, 32'd0,          6'd0, 1'b1}},
		'{OP_INSERT,  6'd1,  32'd5,          1'b1, '{ST_BADPOS,   5'd0, 32'd0,          6'd0, 1'b1}},
		'{OP_RSVD6,   6'd0,  32'd0,          1'b0, '0},
		'{OP_RSVD7,   6'd63, 32'hffff_ffff,  1'b0, '0},
		'{OP_APPEND,  6'd0,  32'h7fff_ffff,  1'b1, '{ST_OK,       5'd0, 32'd0,          6'd1, 1'b1}},
		'{OP_APPEND,  6'd63, 32'h8000_0000,  1'b1, '{ST_OK,       5'd1, 32'd0,          6'd2, 1'b1}},
		'{OP_INSERT,  6'd0,  32'd0,          1'b1, '{ST_OK,       5'd0, 32'd0,          6'd3, 1'b1}},
		'{OP_INSERT,  6'd3,  32'hffff_ffff,  1'b1, '{ST_OK,       5'd3, 32'd0,          6'd4, 1'b1}},
		'{OP_INSERT,  6'd5,  32'd1,          1'b1, '{ST_BADPOS,   5'd0, 32'd0,          6'd4, 1'b1}},
		'{OP_SEARCH,  6'd0,  32'h8000_0000,  1'b1, '{ST_OK,       5'd2, 32'h8000_0000,  6'd4, 1'b1}},
		'{OP_SEARCH,  6'd0,  32'd12345,      1'b1, '{ST_NOTFOUND, 5'd0, 32'd0,          6'd4, 1'b1}},
		'{OP_DISPLAY, 6'd0,  32'd0,          1'b0, '0},
		'{OP_DELETE,  6'd4,  32'd0,          1'b1, '{ST_BADPOS,   5'd0, 32'd0,          6'd4, 1'b1}},
		'{OP_DELETE,  6'd63, 32'd0,          1'b1, '{ST_BADPOS,   5'd0, 32'd0,          6'd4, 1'b1}},
		'{OP_DELETE,  6'd0,  32'd0,          1'b1, '{ST_OK,       5'd0, 32'd0,          6'd3, 1'b1}},
		'{OP_DELETE,  6'd2,  32'd0,          1'b1, '{ST_OK,       5'd2, 32'd0,          6'd2, 1'b1}},
		'{OP_INSERT,  6'd2,  32'h7fff_ffff,  1'b1, '{ST_OK,       5'd2, 32'd0,          6'd3, 1'b1}},
		'{OP_SEARCH,  6'd0,  32'h7fff_ffff,  1'b1, '{ST_OK,       5'd0, 32'h7fff_ffff,  6'd3, 1'b1}},
		'{OP_CLEAR,   6'd0,  32'd0,          1'b1, '{ST_OK,       5'd0, 32'd0,          6'd0, 1'b1}},
		'{OP_DISPLAY, 6'd0,  32'd0,          1'b1, '{ST_EMPTY,    5'd0, 32'd0,          6'd0, 1'b1}}
	};

	logic clk;
	logic arst_n;

	alt_in_if  req_if ();
	alt_out_if rsp_if ();

	array_list_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the list
	logic signed [WORD_W-1:0] list_words [CAPACITY];
	int                       list_len;
	rsp_beat_t                pending_results [$];

	// Travels with each request beat; a typed row carries its own answer
	logic      note_typed;
	rsp_beat_t note_beat;

	int       fails;
	int       cmds_taken;
	int       beats_checked;
	int       quiet_cycles;
	int       deepest;
	int       items_offered;
	bit [4:0] statuses_seen;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void owe(status_t st, int idx, logic [WORD_W-1:0] word, bit fin);
		rsp_beat_t b;
		b.status  = st;
		b.idx     = idx[FIDX_W-1:0];
		b.word    = word;
		b.len     = list_len[LEN_W-1:0];
		b.is_last = fin;
		pending_results.push_back(b);
	endfunction

	function automatic void run_list_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
		logic signed [WORD_W-1:0] val);
		int i;
		int hit;
		int n;
		hit = -1;
		case (op)
			OP_CLEAR: begin
				list_len = 0;
				owe(ST_OK, 0, '0, 1'b1);
			end
			OP_APPEND: begin
				if (list_len >= CAPACITY) begin
					owe(ST_FULL, 0, '0, 1'b1);
				end else begin
					list_words[list_len] = val;
					list_len++;
					owe(ST_OK, list_len - 1, '0, 1'b1);
				end
			end
			OP_INSERT: begin
				// full wins over a bad position
				if (list_len >= CAPACITY) begin
					owe(ST_FULL, 0, '0, 1'b1);
				end else if (int'(pos) > list_len) begin
					owe(ST_BADPOS, 0, '0, 1'b1);
				end else begin
					for (i = list_len; i > int'(pos); i--)
						list_words[i] = list_words[i-1];
					list_words[pos] = val;
					list_len++;
					owe(ST_OK, int'(pos), '0, 1'b1);
				end
			end
			OP_DELETE: begin
				if (list_len == 0) begin
					owe(ST_EMPTY, 0, '0, 1'b1);
				end else if (int'(pos) >= list_len) begin
					owe(ST_BADPOS, 0, '0, 1'b1);
				end else begin
					for (i = int'(pos); i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
					owe(ST_OK, int'(pos), '0, 1'b1);
				end
			end
			OP_SEARCH: begin
				if (list_len == 0) begin
					owe(ST_EMPTY, 0, '0, 1'b1);
				end else begin
					for (i = 0; i < list_len && hit < 0; i++)
						if (list_words[i] == val)
							hit = i;
					if (hit >= 0)
						owe(ST_OK, hit, val, 1'b1);
					else
						owe(ST_NOTFOUND, 0, '0, 1'b1);
				end
			end
			OP_DISPLAY: begin
				n = (list_len < RESULT_LIMIT) ? list_len : RESULT_LIMIT;
				if (n == 0)
					owe(ST_EMPTY, 0, '0, 1'b1);
				for (i = 0; i < n; i++)
					owe(ST_OK, i, list_words[i], i == n - 1);
			end
			default: ;
		endcase
		if (list_len > deepest)
			deepest = list_len;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	// Predict on each request beat, check each result beat
	always @(posedge clk) begin
		int        base;
		rsp_beat_t want;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				base = pending_results.size();
				run_list_command(req_if.operation, req_if.position, req_if.value);
				if (note_typed) begin
					while (pending_results.size() > base)
						void'(pending_results.pop_back());
					pending_results.push_back(note_beat);
				end
				cmds_taken++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat arrived with no command outstanding");
					fails++;
				end else begin
					want = pending_results.pop_front();
					compare_field("status", want.status, rsp_if.status);
					compare_field("found_index", want.idx, rsp_if.found_index);
					compare_field("data_word", want.word, rsp_if.data_word);
					compare_field("length", want.len, rsp_if.length);
					compare_field("last", want.is_last, rsp_if.last);
					statuses_seen[want.status] = 1'b1;
					beats_checked++;
				end
			end
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	task automatic offer(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] val,
		logic typed, rsp_beat_t beat);
		int gap;
		gap = (items_offered % 64 < 16) ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.position  <= pos;
		req_if.value     <= val;
		note_typed       <= typed;
		note_beat        <= beat;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		items_offered++;
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'd0;
			3:       return 32'hffff_ffff;
			4, 5:    return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// Mostly in range, sometimes at the edge, now and then anywhere in the field
	function automatic logic [POS_W-1:0] pick_pos(int span);
		if (span < 0)
			span = 0;
		case ($urandom_range(0, 7))
			0:       return POS_W'($urandom_range(0, 63));
			1:       return POS_W'(span);
			default: return POS_W'($urandom_range(0, span));
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_probe();
		if (list_len > 0 && $urandom_range(0, 3) != 0)
			return list_words[$urandom_range(0, list_len - 1)];
		return pick_word();
	endfunction

	// Create a list: clear, then n appends
	task automatic build_list(int n);
		offer(OP_CLEAR, pick_pos(63), pick_word(), 1'b0, '0);
		repeat (n)
			offer(OP_APPEND, pick_pos(63), pick_word(), 1'b0, '0);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int  rand_start;
		bit  paused;
		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.operation <= '0;
		req_if.position  <= '0;
		req_if.value     <= '0;
		note_typed       <= 1'b0;
		note_beat        <= '0;
		list_len         = 0;
		paused           = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (COMMAND_TABLE[r])
			offer(COMMAND_TABLE[r].op, COMMAND_TABLE[r].pos, COMMAND_TABLE[r].val,
				COMMAND_TABLE[r].typed, COMMAND_TABLE[r].beat);

		// Overfill, then hit the full list from every side
		build_list(CAPACITY + 1);
		offer(OP_INSERT, 6'd40, pick_word(), 1'b0, '0);
		offer(OP_INSERT, 6'd0, pick_word(), 1'b0, '0);
		offer(OP_DISPLAY, 6'd0, 32'd0, 1'b0, '0);
		offer(OP_SEARCH, 6'd0, pick_probe(), 1'b0, '0);
		offer(OP_DELETE, 6'd32, 32'd0, 1'b0, '0);
		offer(OP_DELETE, 6'd31, 32'd0, 1'b0, '0);

		rand_start = items_offered;
		while (items_offered < rand_start + RANDOM_ITEMS) begin
			if (!paused && items_offered >= rand_start + RANDOM_ITEMS / 2) begin
				req_if.valid <= 1'b0;
				wait_drained();
				paused = 1'b1;
			end
			case ($urandom_range(0, 15))
				0:          build_list(($urandom_range(0, 7) == 0) ?
						$urandom_range(CAPACITY - 4, CAPACITY + 2) : $urandom_range(0, 6));
				1, 2, 3:    offer(OP_APPEND, pick_pos(63), pick_word(), 1'b0, '0);
				4, 5, 6:    offer(OP_INSERT, pick_pos(list_len), pick_word(), 1'b0, '0);
				7, 8, 9:    offer(OP_DELETE, pick_pos(list_len - 1), pick_word(), 1'b0, '0);
				10, 11, 12: offer(OP_SEARCH, pick_pos(63), pick_probe(), 1'b0, '0);
				13, 14:     offer(OP_DISPLAY, pick_pos(63), pick_word(), 1'b0, '0);
				default: begin
					if ($urandom_range(0, 3) == 0)
						offer(OP_W'($urandom_range(OP_RSVD6, OP_RSVD7)), pick_pos(63),
							pick_word(), 1'b0, '0);
					else
						offer(OP_DISPLAY, pick_pos(63), pick_word(), 1'b0, '0);
				end
			endcase
		end

		req_if.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d commands and checked %0d result beats; list grew to %0d of %0d.",
			cmds_taken, beats_checked, deepest, CAPACITY);
		$display("Status codes seen, not-found down to ok: %b", statuses_seen);
		if (fails == 0)
			$display("array_list_table: match");
		else
			$display("array_list_table: mismatch");
		$finish;
	end

	// Result side: random stalls, one long hold-off to back the block up
	initial begin
		int stall;
		int rsp_taken;
		bit held;
		rsp_taken = 0;
		held      = 1'b0;
		rsp_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && rsp_taken >= 40) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				held = 1'b1;
			end
			stall = (rsp_taken % 50 < 12) ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid)
				@(posedge clk);
			rsp_taken++;
		end
	end

	initial begin
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("No beat moved on either channel for %0d cycles", QUIET_LIMIT);
		$display("array_list_table: mismatch");
		$finish;
	end

endmodule

FILE: array_list_table.f
hdl/alt_pkg.sv
hdl/alt_if.sv
hdl/alt_ctrl.sv
hdl/alt_dpath.sv
hdl/array_list_table.sv
tb/testbench.sv
